@@ hdl/pid_aw_pkg.sv @@
package pid_aw_pkg;

	localparam int VALUE_W  = 32;
	localparam int SUM_W    = 48;
	localparam int GAIN_W   = 32;
	localparam int ERR_W    = VALUE_W + 1;
	localparam int DIFF_W   = VALUE_W + 2;
	localparam int DRIVE_W  = 19;
	localparam int FRAC_W   = 16;
	localparam int ILO_W    = 16;
	localparam int IHI_W    = SUM_W - ILO_W;
	localparam int ACC_W    = GAIN_W + SUM_W + 2;
	localparam int SHF_W    = ACC_W - FRAC_W;
	localparam int CFG_IDX_W = 2;
	localparam int DRIVE_LIMIT = 229376;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic signed [GAIN_W-1:0]  gain_t;
	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;
	typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

	localparam cfg_idx_t REG_GAIN_P = 2'd0;
	localparam cfg_idx_t REG_GAIN_I = 2'd1;
	localparam cfg_idx_t REG_GAIN_D = 2'd2;

	localparam drive_t DRIVE_HI = drive_t'(DRIVE_LIMIT);
	localparam drive_t DRIVE_LO = drive_t'(-DRIVE_LIMIT);

	typedef struct packed {
		gain_t gain_p;
		gain_t gain_i;
		gain_t gain_d;
	} gains_t;

endpackage

@@ hdl/pid_aw_integ.sv @@
module pid_aw_integ (
	input  pid_aw_pkg::value_t set_point,
	input  pid_aw_pkg::value_t measured,
	input  pid_aw_pkg::sum_t   integral,
	input  pid_aw_pkg::drive_t last_drive,
	output pid_aw_pkg::err_t   err,
	output pid_aw_pkg::sum_t   integral_next
);
	import pid_aw_pkg::*;

	localparam logic signed [SUM_W:0] SMAX = {2'b00, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W:0] SMIN = {2'b11, {(SUM_W-1){1'b0}}};

	logic                    inside_lim;
	logic                    integrate;
	logic signed [SUM_W:0]   sum_ext;

	always_comb begin
		err = ERR_W'(set_point) - ERR_W'(measured);
		inside_lim = (last_drive > DRIVE_LO) && (last_drive < DRIVE_HI);
		integrate = inside_lim
			|| ((last_drive >= DRIVE_HI) && err[ERR_W-1])
			|| ((last_drive <= DRIVE_LO) && !err[ERR_W-1] && (err != '0));
		sum_ext = (SUM_W+1)'(integral) + (SUM_W+1)'(err);
		if (!integrate) begin
			integral_next = integral;
		end else if (sum_ext > SMAX) begin
			integral_next = SMAX[SUM_W-1:0];
		end else if (sum_ext < SMIN) begin
			integral_next = SMIN[SUM_W-1:0];
		end else begin
			integral_next = sum_ext[SUM_W-1:0];
		end
	end

endmodule

@@ hdl/pid_aw_drive.sv @@
module pid_aw_drive (
	input  pid_aw_pkg::gains_t gains,
	input  pid_aw_pkg::err_t   err,
	input  pid_aw_pkg::sum_t   integral,
	input  pid_aw_pkg::diff_t  diff,
	output pid_aw_pkg::drive_t drive,
	output logic               at_limit
);
	import pid_aw_pkg::*;

	localparam logic signed [SHF_W-1:0] LIM_HI = SHF_W'(DRIVE_LIMIT);
	localparam logic signed [SHF_W-1:0] LIM_LO = SHF_W'(-DRIVE_LIMIT);

	logic signed [GAIN_W+ERR_W-1:0]   prod_p;
	logic signed [GAIN_W+IHI_W-1:0]   prod_ihi;
	logic signed [GAIN_W+ILO_W:0]     prod_ilo;
	logic signed [GAIN_W+DIFF_W-1:0]  prod_d;
	logic signed [IHI_W-1:0]          int_hi;
	logic signed [ILO_W:0]            int_lo;
	logic signed [ACC_W-1:0]          acc;
	logic signed [SHF_W-1:0]          shf;

	always_comb begin
		int_hi   = integral[SUM_W-1:ILO_W];
		int_lo   = $signed({1'b0, integral[ILO_W-1:0]});
		prod_p   = gains.gain_p * err;
		prod_ihi = gains.gain_i * int_hi;
		prod_ilo = gains.gain_i * int_lo;
		prod_d   = gains.gain_d * diff;
		acc = ACC_W'(prod_p) + (ACC_W'(prod_ihi) <<< ILO_W) + ACC_W'(prod_ilo)
			+ ACC_W'(prod_d);
		shf = acc[ACC_W-1:FRAC_W];
		if (shf >= LIM_HI) begin
			drive    = DRIVE_HI;
			at_limit = 1'b1;
		end else if (shf <= LIM_LO) begin
			drive    = DRIVE_LO;
			at_limit = 1'b1;
		end else begin
			drive    = shf[DRIVE_W-1:0];
			at_limit = 1'b0;
		end
	end

endmodule

@@ hdl/pid_controller_antiwindup_core.sv @@
// channel | handshake          | word
// --------+--------------------+----------------------------
// in      | in_valid/in_stall  | clear, set_point, measured
// out     | out_valid/out_stall| drive, at_limit
// cfg     | cfg_we             | cfg_index, cfg_data
// One word per cycle sustained while out_stall is low; an accepted word passes through the input
// register, then one pass of the PID math into the result register.
// The integral and last drive feed back from one word to the next within that pass.
// Reset clears the gains, integral, error history and last drive.
// A stalled result holds; the input register holds behind it and in_stall rises.
module pid_controller_antiwindup_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  clear,
	input  pid_aw_pkg::value_t    set_point,
	input  pid_aw_pkg::value_t    measured,
	output logic                  out_valid,
	input  logic                  out_stall,
	output pid_aw_pkg::drive_t    drive,
	output logic                  at_limit,
	input  logic                  cfg_we,
	input  pid_aw_pkg::cfg_idx_t  cfg_index,
	input  pid_aw_pkg::gain_t     cfg_data
);
	import pid_aw_pkg::*;

	gains_t gains_q;
	sum_t   integral_q;
	err_t   last_err_q;
	err_t   older_err_q;
	drive_t last_drive_q;

	logic   valid_s1;
	logic   clear_s1;
	value_t set_point_s1;
	value_t measured_s1;

	logic   valid_s2;
	drive_t drive_s2;
	logic   at_limit_s2;

	logic   accept;
	logic   advance;
	err_t   err;
	sum_t   integral_next;
	diff_t  diff;
	drive_t drive_calc;
	logic   at_limit_calc;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;
	assign diff     = DIFF_W'(last_err_q) - DIFF_W'(older_err_q);

	assign out_valid = valid_s2;
	assign drive     = drive_s2;
	assign at_limit  = at_limit_s2;

	pid_aw_integ u_integ (
		.set_point     (set_point_s1),
		.measured      (measured_s1),
		.integral      (integral_q),
		.last_drive    (last_drive_q),
		.err           (err),
		.integral_next (integral_next)
	);

	pid_aw_drive u_drive (
		.gains    (gains_q),
		.err      (err),
		.integral (integral_next),
		.diff     (diff),
		.drive    (drive_calc),
		.at_limit (at_limit_calc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_GAIN_P: gains_q.gain_p <= cfg_data;
				REG_GAIN_I: gains_q.gain_i <= cfg_data;
				REG_GAIN_D: gains_q.gain_d <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			clear_s1     <= clear;
			set_point_s1 <= set_point;
			measured_s1  <= measured;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2     <= 1'b0;
			integral_q   <= '0;
			last_err_q   <= '0;
			older_err_q  <= '0;
			last_drive_q <= '0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			if (clear_s1) begin
				integral_q   <= '0;
				last_err_q   <= '0;
				older_err_q  <= '0;
				last_drive_q <= '0;
			end else begin
				integral_q   <= integral_next;
				last_err_q   <= err;
				older_err_q  <= last_err_q;
				last_drive_q <= drive_calc;
			end
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			drive_s2    <= clear_s1 ? '0 : drive_calc;
			at_limit_s2 <= clear_s1 ? 1'b0 : at_limit_calc;
		end
	end

endmodule

@@ verif/pid_controller_antiwindup_core_tb.sv @@
module pid_controller_antiwindup_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pid_aw_pkg::*;

	localparam cfg_idx_t REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 800000;
	localparam int ITEMS_PER_SETTING = 290;
	localparam int SAT_RUN = 40;
	localparam longint SUM_MAX = (longint'(1) <<< (SUM_W - 1)) - 1;
	localparam longint SUM_MIN = -SUM_MAX - 1;
	localparam value_t VALUE_MAX = 32'sh7FFFFFFF;
	localparam value_t VALUE_MIN = 32'sh80000000;

	typedef struct {
		drive_t drive;
		logic   at_limit;
	} drive_word_t;

	class drive_tracker;
		longint gain_p, gain_i, gain_d;
		longint integ, err_prev, err_prev2, drive_prev;
		drive_word_t due_drives[$];
		int mismatches;

		function new();
			gain_p = 0;
			gain_i = 0;
			gain_d = 0;
			integ = 0;
			err_prev = 0;
			err_prev2 = 0;
			drive_prev = 0;
			mismatches = 0;
		endfunction

		function void set_gain(cfg_idx_t idx, gain_t val);
			case (idx)
				REG_GAIN_P: gain_p = longint'(val);
				REG_GAIN_I: gain_i = longint'(val);
				REG_GAIN_D: gain_d = longint'(val);
				default: ;
			endcase
		endfunction

		function logic signed [95:0] widen(longint v);
			logic signed [95:0] w;
			w = v;
			return w;
		endfunction

		function void take_sample(logic clr, value_t sp, value_t ms);
			longint err, diff, nsum, drv;
			logic signed [95:0] acc;
			logic signed [95:0] q;
			logic integrate;
			drive_word_t w;
			if (clr) begin
				integ = 0;
				err_prev = 0;
				err_prev2 = 0;
				drive_prev = 0;
				w.drive = '0;
				w.at_limit = 1'b0;
				due_drives.push_back(w);
				return;
			end
			err = longint'(sp) - longint'(ms);
			integrate = (drive_prev > -DRIVE_LIMIT && drive_prev < DRIVE_LIMIT) ||
				(drive_prev >= DRIVE_LIMIT && err < 0) ||
				(drive_prev <= -DRIVE_LIMIT && err > 0);
			if (integrate) begin
				nsum = integ + err;
				if (nsum > SUM_MAX)
					nsum = SUM_MAX;
				else if (nsum < SUM_MIN)
					nsum = SUM_MIN;
				integ = nsum;
			end
			diff = err_prev - err_prev2;
			err_prev2 = err_prev;
			err_prev = err;
			acc = widen(gain_p) * widen(err) + widen(gain_i) * widen(integ) +
				widen(gain_d) * widen(diff);
			q = acc >>> FRAC_W;
			if (q > DRIVE_LIMIT)
				drv = DRIVE_LIMIT;
			else if (q < -DRIVE_LIMIT)
				drv = -DRIVE_LIMIT;
			else
				drv = $signed(q[63:0]);
			drive_prev = drv;
			w.drive = drive_t'(drv);
			w.at_limit = (drv == DRIVE_LIMIT || drv == -DRIVE_LIMIT);
			due_drives.push_back(w);
		endfunction

		function void report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endfunction

		function void match_drive(drive_t d, logic lim);
			drive_word_t w;
			if (due_drives.size() == 0) begin
				report($sformatf("unexpected word drive=%0d at_limit=%0b", d, lim));
				return;
			end
			w = due_drives.pop_front();
			if (d !== w.drive)
				report($sformatf("drive got %0d want %0d", d, w.drive));
			if (lim !== w.at_limit)
				report($sformatf("at_limit got %0b want %0b (drive %0d)", lim, w.at_limit,
					w.drive));
		endfunction

		function int pending();
			return due_drives.size();
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	logic     clear;
	value_t   set_point;
	value_t   measured;
	logic     out_valid;
	logic     out_stall;
	drive_t   drive;
	logic     at_limit;
	logic     cfg_we;
	cfg_idx_t cfg_index;
	gain_t    cfg_data;

	drive_tracker tracker;
	int send_idle;
	int recv_idle;
	int cycles;

	pid_controller_antiwindup_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.clear     (clear),
		.set_point (set_point),
		.measured  (measured),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive),
		.at_limit  (at_limit),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	initial begin
		tracker = new();
		send_idle = 0;
		recv_idle = 0;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = (arst_n && $urandom_range(0, 99) < recv_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				tracker.match_drive(drive, at_limit);
			if (in_valid && !in_stall)
				tracker.take_sample(clear, set_point, measured);
		end
	end

	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("** pid_controller_antiwindup_core: FAILED **");
		$finish;
	end

	task automatic send_word(logic c, value_t sp, value_t ms);
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		clear = c;
		set_point = sp;
		measured = ms;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic write_gain(cfg_idx_t idx, gain_t val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		tracker.set_gain(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (tracker.pending() != 0)
			@(negedge clk);
		repeat (6) @(negedge clk);
	endtask

	initial begin
		gain_t gp[6], gi[6], gd[6];
		value_t corners[5];
		value_t sp, ms, base;
		logic c;
		int sel, delta;

		arst_n = 1'b0;
		in_valid = 1'b0;
		clear = 1'b0;
		set_point = '0;
		measured = '0;
		cfg_we = 1'b0;
		cfg_index = REG_GAIN_P;
		cfg_data = '0;
		sp = '0;
		ms = '0;
		corners = '{VALUE_MAX, VALUE_MIN, 32'sd0, -32'sd1, 32'sd1};
		gp = '{32'sd65536, -32'sd131072, 32'sh7FFFFFFF, 32'sd0, 32'sh80000000, 32'sd0};
		gi = '{32'sd1024, -32'sd655, 32'sh80000000, 32'sd16384, 32'sh7FFFFFFF, 32'sd0};
		gd = '{32'sd32768, -32'sd65536, 32'sh7FFFFFFF, 32'sd0, 32'sh80000000, 32'sd0};
		gp[5] = gain_t'(int'($urandom_range(0, 524288)) - 262144);
		gi[5] = gain_t'(int'($urandom_range(0, 524288)) - 262144);
		gd[5] = gain_t'(int'($urandom_range(0, 524288)) - 262144);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 14;
		recv_idle = 76;

		// gains still at reset
		send_word(1'b0, 32'sh12345678, 32'sd0);
		send_word(1'b1, VALUE_MAX, VALUE_MIN);
		drain();

		write_gain(REG_GAIN_P, 32'sd65536);
		write_gain(REG_GAIN_I, 32'sd0);
		write_gain(REG_GAIN_D, 32'sd0);
		send_word(1'b0, 32'sd229376, 32'sd0);
		send_word(1'b0, 32'sd229375, 32'sd0);
		send_word(1'b0, -32'sd229376, 32'sd0);
		send_word(1'b0, -32'sd229377, 32'sd0);
		send_word(1'b0, VALUE_MAX, VALUE_MIN);
		send_word(1'b0, VALUE_MIN, VALUE_MAX);
		send_word(1'b0, 32'sd1, 32'sd0);
		send_word(1'b0, -32'sd1, 32'sd0);
		drain();

		// fractional gains: floor on both signs, lagged derivative, windup hold
		write_gain(REG_GAIN_P, 32'sd32768);
		write_gain(REG_GAIN_I, 32'sd16384);
		write_gain(REG_GAIN_D, 32'sd131072);
		send_word(1'b1, 32'sd0, 32'sd0);
		send_word(1'b0, 32'sd1, 32'sd0);
		send_word(1'b0, -32'sd1, 32'sd0);
		send_word(1'b0, 32'sd65536, 32'sd0);
		send_word(1'b0, 32'sd600000, 32'sd0);
		send_word(1'b0, 32'sd600000, 32'sd0);
		send_word(1'b0, 32'sd0, 32'sd1000);
		send_word(1'b0, -32'sd900000, 32'sd0);
		send_word(1'b0, -32'sd900000, 32'sd0);
		send_word(1'b0, 32'sd5000, 32'sd0);
		send_word(1'b0, 32'sd0, 32'sd0);
		drain();

		for (int k = 0; k < 6; k++) begin
			if (k == 2) begin
				send_idle = 76;
				recv_idle = 14;
			end
			if (k == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			write_gain(REG_GAIN_P, gp[k]);
			write_gain(REG_GAIN_I, gi[k]);
			write_gain(REG_GAIN_D, gd[k]);
			if (k == 1)
				write_gain(REG_UNUSED, gain_t'($urandom));
			send_word(1'b1, sp, ms);
			for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
				sel = $urandom_range(0, 99);
				c = 1'b0;
				base = $urandom;
				base = base >>> 1;
				if (sel < 45) begin
					delta = int'($urandom_range(0, 524288)) - 262144;
					sp = base + value_t'(delta);
					ms = base;
				end else if (sel < 62) begin
					delta = int'($urandom_range(0, 32)) - 16;
					sp = base + value_t'(delta);
					ms = base;
				end else if (sel < 80) begin
					sp = $urandom;
					ms = $urandom;
				end else if (sel < 95) begin
					sp = corners[$urandom_range(0, 4)];
					ms = corners[$urandom_range(0, 4)];
				end else begin
					c = 1'b1;
					sp = $urandom;
					ms = $urandom;
				end
				send_word(c, sp, ms);
			end
			drain();
		end

		// push the integral hard both ways with zero gains, then expose its sign
		write_gain(REG_GAIN_P, 32'sd0);
		write_gain(REG_GAIN_I, 32'sd0);
		write_gain(REG_GAIN_D, 32'sd0);
		send_word(1'b1, 32'sd0, 32'sd0);
		for (int n = 0; n < SAT_RUN; n++)
			send_word(1'b0, VALUE_MAX, VALUE_MIN);
		drain();
		write_gain(REG_GAIN_I, 32'sd1);
		send_word(1'b0, 32'sd0, 32'sd0);
		send_word(1'b0, VALUE_MAX, VALUE_MIN);
		drain();
		write_gain(REG_GAIN_I, 32'sd0);
		send_word(1'b1, 32'sd0, 32'sd0);
		for (int n = 0; n < SAT_RUN; n++)
			send_word(1'b0, VALUE_MIN, VALUE_MAX);
		drain();
		write_gain(REG_GAIN_I, 32'sd1);
		send_word(1'b0, 32'sd0, 32'sd0);
		send_word(1'b0, VALUE_MIN, VALUE_MAX);
		send_word(1'b0, 32'sd7, 32'sd0);
		drain();

		if (tracker.mismatches == 0 && tracker.pending() == 0)
			$display("** pid_controller_antiwindup_core: PASSED **");
		else
			$display("** pid_controller_antiwindup_core: FAILED **");
		$finish;
	end

endmodule
